@@ hdl/hpgl_pkg.sv @@
package hpgl_pkg;

	// numbers outside the signed range of this many bits read as 0
	localparam int COORD_BITS = 32;
	localparam int ACC_BITS   = COORD_BITS + 4;
	localparam int OUT_BITS   = 32;

	// result queue; depth must be a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic [15:0] OP_PU = 16'h5055;
	localparam logic [15:0] OP_PD = 16'h5044;
	localparam logic [15:0] OP_IN = 16'h494E;
	localparam logic [15:0] OP_SP = 16'h5350;
	localparam logic [15:0] OP_FS = 16'h4653;
	localparam logic [15:0] OP_VS = 16'h5653;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef struct packed {
		logic                       kind;
		logic signed [OUT_BITS-1:0] x;
		logic signed [OUT_BITS-1:0] y;
		logic                       first;
		logic                       last;
	} result_t;

	// results produced by one character, r0 goes out before r1
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

@@ hdl/hpgl_cmd.sv @@
module hpgl_cmd (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [7:0]    text_char,
	input  logic          file_start,
	output hpgl_pkg::push_t push
);
	import hpgl_pkg::*;

	typedef enum logic [1:0] {PH_LEAD, PH_SIGN, PH_DIGITS, PH_TRAIL} phase_t;

	logic [OUT_BITS-1:0]   pen_x_q, pen_x_d, pen_y_q, pen_y_d;
	logic [15:0]           opc_q, opc_d;
	logic [1:0]            cnt_q, cnt_d;
	logic [COORD_BITS-1:0] acc_q, acc_d;
	logic                  neg_q, neg_d, inv_q, inv_d;
	phase_t                ph_q, ph_d;
	logic [OUT_BITS-1:0]   early_q, early_d;
	logic                  odd_q, odd_d;
	logic [1:0]            seen_q, seen_d;
	logic [OUT_BITS-1:0]   hx_q, hx_d, hy_q, hy_d;
	logic                  hv_q, hv_d, hf_q, hf_d;
	logic                  halt_q, halt_d;
	logic [OUT_BITS-1:0]   val;
	logic [ACC_BITS-1:0]   acc_next;
	logic [ACC_BITS-1:0]   limit;
	logic                  blank, digit, is_pu, is_pd, is_nop;

	assign limit = ACC_BITS'(1) << (COORD_BITS - 1);

	// value of the number read so far, truncated/sign-extended to the output width
	function automatic logic [OUT_BITS-1:0] num_value(
		input logic [COORD_BITS-1:0] acc,
		input logic                  neg,
		input logic                  inv,
		input phase_t                ph
	);
		logic [COORD_BITS-1:0]              v;
		logic signed [COORD_BITS+OUT_BITS-1:0] ext;
		v = '0;
		if (!inv && (ph == PH_DIGITS || ph == PH_TRAIL)) begin
			if (neg)
				v = -acc;
			else if (!acc[COORD_BITS-1])
				v = acc;
		end
		ext = (COORD_BITS+OUT_BITS)'(signed'(v));
		return ext[OUT_BITS-1:0];
	endfunction

	always_comb begin
		pen_x_d = pen_x_q;
		pen_y_d = pen_y_q;
		opc_d   = opc_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		inv_d   = inv_q;
		ph_d    = ph_q;
		early_d = early_q;
		odd_d   = odd_q;
		seen_d  = seen_q;
		hx_d    = hx_q;
		hy_d    = hy_q;
		hv_d    = hv_q;
		hf_d    = hf_q;
		halt_d  = halt_q;
		push    = '0;
		val     = '0;
		acc_next = '0;
		blank   = 1'b0;
		digit   = 1'b0;
		is_pu   = 1'b0;
		is_pd   = 1'b0;
		is_nop  = 1'b0;

		if (go && file_start) begin
			pen_x_d = '0;
			pen_y_d = '0;
			halt_d  = 1'b0;
			opc_d   = '0;
			cnt_d   = '0;
			acc_d   = '0;
			neg_d   = 1'b0;
			inv_d   = 1'b0;
			ph_d    = PH_LEAD;
			early_d = '0;
			odd_d   = 1'b0;
			seen_d  = '0;
			hx_d    = '0;
			hy_d    = '0;
			hv_d    = 1'b0;
			hf_d    = 1'b0;
		end

		if (go && !halt_d && text_char != CH_LF) begin
			val    = num_value(acc_d, neg_d, inv_d, ph_d);
			is_pu  = (cnt_d == 2'd2) && (opc_d == OP_PU);
			is_pd  = (cnt_d == 2'd2) && (opc_d == OP_PD);
			is_nop = (cnt_d == 2'd2) && (opc_d == OP_IN || opc_d == OP_SP ||
				opc_d == OP_FS || opc_d == OP_VS);

			if (text_char == CH_SEMI) begin
				if (is_pu) begin
					pen_x_d = (seen_d == 2'd0) ? val : early_d;
					pen_y_d = val;
				end else if (is_pd) begin
					if (hv_d) begin
						push.r0 = '{KIND_POINT, hx_d, hy_d, hf_d, !odd_d};
						if (odd_d) begin
							push.r1 = '{KIND_POINT, early_d, val, 1'b0, 1'b1};
							push.n  = 2'd2;
						end else begin
							push.n = 2'd1;
						end
					end
				end else if (!is_nop) begin
					push.r0 = '{KIND_ERROR, '0, '0, 1'b0, 1'b1};
					push.n  = 2'd1;
					halt_d  = 1'b1;
				end
				opc_d   = '0;
				cnt_d   = '0;
				acc_d   = '0;
				neg_d   = 1'b0;
				inv_d   = 1'b0;
				ph_d    = PH_LEAD;
				early_d = '0;
				odd_d   = 1'b0;
				seen_d  = '0;
				hx_d    = '0;
				hy_d    = '0;
				hv_d    = 1'b0;
				hf_d    = 1'b0;
			end else if (cnt_d != 2'd2) begin
				opc_d = {opc_d[7:0], text_char};
				cnt_d = cnt_d + 2'd1;
				if (cnt_d == 2'd2 && opc_d == OP_PD) begin
					hx_d = pen_x_d;
					hy_d = pen_y_d;
					hv_d = 1'b1;
					hf_d = 1'b1;
				end
			end else if (text_char == CH_COMMA) begin
				if (is_pu) begin
					early_d = val;
					if (seen_d != 2'd2)
						seen_d = seen_d + 2'd1;
				end else if (is_pd) begin
					if (!odd_d) begin
						early_d = val;
						odd_d   = 1'b1;
					end else begin
						if (hv_d) begin
							push.r0 = '{KIND_POINT, hx_d, hy_d, hf_d, 1'b0};
							push.n  = 2'd1;
						end
						hx_d  = early_d;
						hy_d  = val;
						hv_d  = 1'b1;
						hf_d  = 1'b0;
						odd_d = 1'b0;
					end
				end
				acc_d = '0;
				neg_d = 1'b0;
				inv_d = 1'b0;
				ph_d  = PH_LEAD;
			end else if (!inv_d) begin
				digit = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
				blank = (text_char == CH_SPACE) || (text_char == CH_TAB) ||
					(text_char == CH_VT) || (text_char == CH_FF) ||
					(text_char == CH_CR);
				// acc*10 + digit; exceeding the magnitude limit poisons the number
				acc_next = (ACC_BITS'(acc_d) << 3) + (ACC_BITS'(acc_d) << 1) +
					ACC_BITS'(text_char - CH_ZERO);
				if (digit && ph_d != PH_TRAIL) begin
					if (acc_next > limit)
						inv_d = 1'b1;
					else
						acc_d = acc_next[COORD_BITS-1:0];
					ph_d = PH_DIGITS;
				end else if ((text_char == CH_PLUS || text_char == CH_MINUS) &&
					ph_d == PH_LEAD) begin
					neg_d = (text_char == CH_MINUS);
					ph_d  = PH_SIGN;
				end else if (blank && ph_d != PH_SIGN) begin
					if (ph_d == PH_DIGITS)
						ph_d = PH_TRAIL;
				end else begin
					inv_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			opc_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			inv_q   <= 1'b0;
			ph_q    <= PH_LEAD;
			early_q <= '0;
			odd_q   <= 1'b0;
			seen_q  <= '0;
			hx_q    <= '0;
			hy_q    <= '0;
			hv_q    <= 1'b0;
			hf_q    <= 1'b0;
			halt_q  <= 1'b0;
		end else begin
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			opc_q   <= opc_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			inv_q   <= inv_d;
			ph_q    <= ph_d;
			early_q <= early_d;
			odd_q   <= odd_d;
			seen_q  <= seen_d;
			hx_q    <= hx_d;
			hy_q    <= hy_d;
			hv_q    <= hv_d;
			hf_q    <= hf_d;
			halt_q  <= halt_d;
		end
	end

endmodule

@@ hdl/hpgl_rfifo.sv @@
module hpgl_rfifo (
	input  logic              clk,
	input  logic              arst_n,
	input  hpgl_pkg::push_t   push,
	input  logic              out_stall,
	output logic              out_valid,
	output hpgl_pkg::result_t head,
	output logic              room
);
	import hpgl_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   rd_q, wr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	// room for the worst case of two words from one character
	assign room      = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_q + FIFO_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop)
				rd_q <= rd_q + FIFO_AW'(1);
			wr_q  <= wr_q + FIFO_AW'(push.n);
			cnt_q <= cnt_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

endmodule

@@ hdl/hpgl_pen_path_parser_unit.sv @@
// HPGL pen path parser. Takes one text character per cycle and turns PD commands into polyline
// points (kind 0) and unknown opcodes into an error word (kind 1), after which everything is
// ignored until a character with file_start set. A character is registered on acceptance and
// processed once the result queue has room; its words are then written into the queue, whose
// head drives the output. A new character is taken every cycle as long as the four-entry
// result queue has room for two more words; a stalled output fills the queue and then stalls
// the input.
module hpgl_pen_path_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_char,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic        first_point,
	output logic        last_point
);
	import hpgl_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       fs_s1;
	logic       room;
	logic       go;
	logic       load;
	push_t      push;
	result_t    head;

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= text_char;
			fs_s1   <= file_start;
		end
	end

	hpgl_cmd u_cmd (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.text_char  (char_s1),
		.file_start (fs_s1),
		.push       (push)
	);

	hpgl_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign kind        = head.kind;
	assign point_x     = head.x;
	assign point_y     = head.y;
	assign first_point = head.first;
	assign last_point  = head.last;

endmodule
